// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/fbt_pkg.sv =====
// ----------------------------------------------------------------------------
// fbt_pkg
// Types, codes and defaults of the fraction to balanced ternary converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbt_pkg;

    localparam int VALUE_BITS_DEF     = 31;
    localparam int MAX_FRAC_TRITS_DEF = 24;

    // Balanced digit codes on the result port.
    localparam logic [1:0] TRIT_ZERO = 2'd0;
    localparam logic [1:0] TRIT_POS  = 2'd1;
    localparam logic [1:0] TRIT_NEG  = 2'd2;

    // Offset digits held in the buffer after the add-one pass.
    localparam logic [1:0] OFF_NEG  = 2'd0;
    localparam logic [1:0] OFF_ZERO = 2'd1;
    localparam logic [1:0] OFF_POS  = 2'd2;

    typedef struct packed {
        logic [30:0] numerator;
        logic [30:0] denominator;
    } operand_t;

    typedef struct packed {
        logic [1:0] trit;
        logic       in_fraction;
        logic       truncated;
        logic       last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_INT,
        ST_FRAC,
        ST_CONV_F,
        ST_CONV_I,
        ST_FIN,
        ST_TOP,
        ST_OUT_I,
        ST_OUT_F
    } state_t;

    function automatic logic [1:0] code_from_offset(input logic [1:0] off);
        logic [1:0] code;
        unique case (off)
            OFF_NEG:  code = TRIT_NEG;
            OFF_ZERO: code = TRIT_ZERO;
            OFF_POS:  code = TRIT_POS;
            default:  code = TRIT_ZERO;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fraction_to_balanced_ternary.sv =====
// ----------------------------------------------------------------------------
// fraction_to_balanced_ternary
// Converts numerator / denominator into a stream of balanced ternary digits.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                        Payload
// -------   ---------  -------------------------------  -----------------------
// command   in         start high and busy low          operand (operand_t)
// digit     out        result_valid, one cycle, no hold result (result_t)
//
// An item passes from its transfer through the bit-serial divider and the
// one digit per cycle expansion loops, then the add-one and output passes;
// every pass goes through the single read and write port of the digit
// buffer. Busy stays high until the last digit is read from the buffer, so
// no new item is taken before the previous one is through.
// Reset is asynchronous and active low and returns the controller to idle;
// the digit buffer needs no clearing because every item writes each entry it
// later reads. The receiver cannot stall, so each digit is shown for exactly
// one cycle.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fraction_to_balanced_ternary #(
    parameter int VALUE_BITS     = fbt_pkg::VALUE_BITS_DEF,
    parameter int MAX_FRAC_TRITS = fbt_pkg::MAX_FRAC_TRITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire fbt_pkg::operand_t operand,
    output logic                  result_valid,
    output fbt_pkg::result_t      result
);

    import fbt_pkg::*;

    // Buffer layout: integer digits from address 0 upward (least significant
    // first, one spare slot for a carry out of the top), fraction digits from
    // FRAC_BASE upward (most significant first).
    localparam int INT_SLOTS = (VALUE_BITS * 7) / 11 + 2;
    localparam int FRAC_BASE = INT_SLOTS + 1;
    localparam int BUF_DEPTH = FRAC_BASE + MAX_FRAC_TRITS;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int NFW       = $clog2(MAX_FRAC_TRITS + 1);
    localparam int CW        = $clog2(VALUE_BITS);
    localparam int XW        = (VALUE_BITS > 31) ? VALUE_BITS : 31;

    // Reciprocal of three for an exact quotient of any VALUE_BITS value.
    localparam logic [VALUE_BITS+1:0] POW2    = {1'b1, {(VALUE_BITS + 1){1'b0}}};
    localparam logic [VALUE_BITS+1:0] RECIP_W = POW2 / 3 + 1;

    // Digit buffer and its registered read data.
    logic [1:0]    digit_buffer [BUF_DEPTH];
    logic [1:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [1:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] qn_reg, qn_next;     // numerator, then quotient
    logic [VALUE_BITS-1:0] rem_reg, rem_next;   // division and fraction remainder
    logic [VALUE_BITS-1:0] den_reg, den_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         ni_reg, ni_next;
    logic [NFW-1:0]        nf_reg, nf_next;
    logic [NFW-1:0]        cf_reg, cf_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         top_reg, top_next;
    logic [NFW-1:0]        nfo_reg, nfo_next;
    logic                  found_reg, found_next;
    logic                  carry_reg, carry_next;
    logic                  trunc_reg, trunc_next;

    // Tag of the buffer read that the add-one pass finishes in the next cycle.
    logic          conv_vld_reg, conv_vld_next;
    logic          conv_frac_reg, conv_frac_next;
    logic [AW-1:0] conv_addr_reg, conv_addr_next;
    logic [AW-1:0] conv_idx_reg, conv_idx_next;

    // Tag of the buffer read that becomes the next digit on the result port.
    logic out_vld_reg, out_vld_next;
    logic out_frac_reg, out_frac_next;
    logic out_last_reg, out_last_next;

    logic                  accept;
    logic [XW-1:0]         num_ext;
    logic [XW-1:0]         den_ext;
    logic [VALUE_BITS-1:0] den_in;
    logic                  div_last;
    logic                  int_done;
    logic                  frac_done;

    logic [VALUE_BITS:0]     div_shift;
    logic [VALUE_BITS:0]     div_diff;
    logic [2*VALUE_BITS-1:0] prod;
    logic [VALUE_BITS-2:0]   q3;
    logic [VALUE_BITS+1:0]   r3;
    logic [VALUE_BITS+1:0]   r3_sub;
    logic [VALUE_BITS+1:0]   den1;
    logic [VALUE_BITS+1:0]   den2;
    logic [1:0]              frac_digit;
    logic [2:0]              conv_sum;
    logic [1:0]              conv_off;
    logic                    conv_carry;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Inputs are taken at VALUE_BITS; a zero denominator counts as one.
    assign num_ext = XW'(operand.numerator);
    assign den_ext = XW'(operand.denominator);
    assign den_in  = (den_ext[VALUE_BITS-1:0] == '0) ? VALUE_BITS'(1)
                                                     : den_ext[VALUE_BITS-1:0];

    assign div_last  = (cnt_reg == CW'(VALUE_BITS - 1));
    assign int_done  = (qn_reg == '0) || (ni_reg == AW'(INT_SLOTS));
    assign frac_done = (rem_reg == '0) || (nf_reg == NFW'(MAX_FRAC_TRITS));

    // Restoring division step: one quotient bit per cycle.
    assign div_shift = {rem_reg, qn_reg[VALUE_BITS-1]};
    assign div_diff  = div_shift - {1'b0, den_reg};

    // Quotient by three through the reciprocal; the low digit follows from
    // q - 3 * (q / 3), which modulo four is q + q / 3.
    assign prod = (2 * VALUE_BITS)'(qn_reg) * (2 * VALUE_BITS)'(RECIP_W[VALUE_BITS-1:0]);
    assign q3   = prod[2*VALUE_BITS-1:VALUE_BITS+1];

    // Fraction step: three times the remainder against one and two
    // denominators gives the next digit.
    assign r3   = {2'b00, rem_reg} + {1'b0, rem_reg, 1'b0};
    assign den1 = {2'b00, den_reg};
    assign den2 = {1'b0, den_reg, 1'b0};

    always_comb
    begin
        if (r3 >= den2)
        begin
            frac_digit = 2'd2;
            r3_sub     = r3 - den2;
        end
        else if (r3 >= den1)
        begin
            frac_digit = 2'd1;
            r3_sub     = r3 - den1;
        end
        else
        begin
            frac_digit = 2'd0;
            r3_sub     = r3;
        end
    end

    // Add-one pass: digit plus one plus the incoming carry, split into an
    // offset digit and an outgoing carry.
    assign conv_sum = {1'b0, rd_data_reg} + 3'd1 + {2'b00, carry_reg};

    always_comb
    begin
        case (conv_sum)
            3'd1:    begin conv_off = 2'd1; conv_carry = 1'b0; end
            3'd2:    begin conv_off = 2'd2; conv_carry = 1'b0; end
            3'd3:    begin conv_off = 2'd0; conv_carry = 1'b1; end
            3'd4:    begin conv_off = 2'd1; conv_carry = 1'b1; end
            default: begin conv_off = 2'd0; conv_carry = 1'b0; end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_INT;
            end
            ST_INT:
            begin
                if (int_done)
                    state_next = ST_FRAC;
            end
            ST_FRAC:
            begin
                if (frac_done)
                    state_next = (nf_reg != '0) ? ST_CONV_F : ST_CONV_I;
            end
            ST_CONV_F:
            begin
                if (cf_reg == '0)
                    state_next = ST_CONV_I;
            end
            ST_CONV_I:
            begin
                if (ptr_reg == ni_reg - AW'(1))
                    state_next = ST_FIN;
            end
            ST_FIN:
                state_next = ST_TOP;
            ST_TOP:
                state_next = ST_OUT_I;
            ST_OUT_I:
            begin
                if (ptr_reg == '0)
                    state_next = (nfo_reg == '0) ? ST_IDLE : ST_OUT_F;
            end
            ST_OUT_F:
            begin
                if (cf_reg == nfo_reg - NFW'(1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and buffer control.
    always_comb
    begin
        qn_next        = qn_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        ni_next        = ni_reg;
        nf_next        = nf_reg;
        cf_next        = cf_reg;
        ptr_next       = ptr_reg;
        top_next       = top_reg;
        nfo_next       = nfo_reg;
        found_next     = found_reg;
        carry_next     = carry_reg;
        trunc_next     = trunc_reg;
        conv_vld_next  = 1'b0;
        conv_frac_next = conv_frac_reg;
        conv_addr_next = conv_addr_reg;
        conv_idx_next  = conv_idx_reg;
        out_vld_next   = 1'b0;
        out_frac_next  = out_frac_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_re         = 1'b0;
        mem_ra         = '0;

        // Write back the digit read in the previous cycle. Walking from the
        // least significant digit upward, the first fraction digit that is
        // not zero sets the fraction length, and the highest integer digit
        // that is not zero sets where the output starts.
        if (conv_vld_reg)
        begin
            mem_we     = 1'b1;
            mem_wa     = conv_addr_reg;
            mem_wd     = conv_off;
            carry_next = conv_carry;
            if (conv_frac_reg)
            begin
                if (!found_reg && conv_off != OFF_ZERO)
                begin
                    nfo_next   = NFW'(conv_idx_reg) + NFW'(1);
                    found_next = 1'b1;
                end
            end
            else if (conv_off != OFF_ZERO)
            begin
                top_next = conv_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    qn_next    = num_ext[VALUE_BITS-1:0];
                    rem_next   = '0;
                    den_next   = den_in;
                    cnt_next   = '0;
                    top_next   = '0;
                    nfo_next   = '0;
                    found_next = 1'b0;
                    carry_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (div_shift >= {1'b0, den_reg})
                begin
                    rem_next = div_diff[VALUE_BITS-1:0];
                    qn_next  = {qn_reg[VALUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[VALUE_BITS-1:0];
                    qn_next  = {qn_reg[VALUE_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                ni_next  = '0;
            end
            ST_INT:
            begin
                if (!int_done)
                begin
                    mem_we  = 1'b1;
                    mem_wa  = ni_reg;
                    mem_wd  = qn_reg[1:0] + q3[1:0];
                    qn_next = {1'b0, q3};
                    ni_next = ni_reg + AW'(1);
                end
                else
                begin
                    // A zero quotient still sends one integer digit.
                    if (ni_reg == '0)
                    begin
                        mem_we  = 1'b1;
                        mem_wa  = '0;
                        mem_wd  = 2'd0;
                        ni_next = AW'(1);
                    end
                    nf_next = '0;
                end
            end
            ST_FRAC:
            begin
                if (!frac_done)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = AW'(FRAC_BASE) + AW'(nf_reg);
                    mem_wd   = frac_digit;
                    rem_next = r3_sub[VALUE_BITS-1:0];
                    nf_next  = nf_reg + NFW'(1);
                end
                else
                begin
                    trunc_next = (rem_reg != '0);
                    cf_next    = nf_reg - NFW'(1);
                    ptr_next   = '0;
                end
            end
            ST_CONV_F:
            begin
                mem_re         = 1'b1;
                mem_ra         = AW'(FRAC_BASE) + AW'(cf_reg);
                conv_vld_next  = 1'b1;
                conv_frac_next = 1'b1;
                conv_addr_next = AW'(FRAC_BASE) + AW'(cf_reg);
                conv_idx_next  = AW'(cf_reg);
                cf_next        = cf_reg - NFW'(1);
                ptr_next       = '0;
            end
            ST_CONV_I:
            begin
                mem_re         = 1'b1;
                mem_ra         = ptr_reg;
                conv_vld_next  = 1'b1;
                conv_frac_next = 1'b0;
                conv_addr_next = ptr_reg;
                conv_idx_next  = ptr_reg;
                ptr_next       = ptr_reg + AW'(1);
            end
            ST_FIN:
            begin
            end
            ST_TOP:
            begin
                // A carry out of the top digit adds a plus one digit above it.
                if (carry_reg)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = ni_reg;
                    mem_wd   = OFF_POS;
                    ptr_next = ni_reg;
                end
                else
                begin
                    ptr_next = top_reg;
                end
            end
            ST_OUT_I:
            begin
                mem_re        = 1'b1;
                mem_ra        = ptr_reg;
                out_vld_next  = 1'b1;
                out_frac_next = 1'b0;
                out_last_next = (ptr_reg == '0) && (nfo_reg == '0);
                ptr_next      = ptr_reg - AW'(1);
                cf_next       = '0;
            end
            ST_OUT_F:
            begin
                mem_re        = 1'b1;
                mem_ra        = AW'(FRAC_BASE) + AW'(cf_reg);
                out_vld_next  = 1'b1;
                out_frac_next = 1'b1;
                out_last_next = (cf_reg == nfo_reg - NFW'(1));
                cf_next       = cf_reg + NFW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Digit buffer: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_buffer[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= digit_buffer[mem_ra];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            conv_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            conv_vld_reg <= conv_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Working registers; each is loaded before it is used.
    always_ff @(posedge clk)
    begin
        qn_reg        <= qn_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        cnt_reg       <= cnt_next;
        ni_reg        <= ni_next;
        nf_reg        <= nf_next;
        cf_reg        <= cf_next;
        ptr_reg       <= ptr_next;
        top_reg       <= top_next;
        nfo_reg       <= nfo_next;
        found_reg     <= found_next;
        carry_reg     <= carry_next;
        trunc_reg     <= trunc_next;
        conv_frac_reg <= conv_frac_next;
        conv_addr_reg <= conv_addr_next;
        conv_idx_reg  <= conv_idx_next;
        out_frac_reg  <= out_frac_next;
        out_last_reg  <= out_last_next;
    end

    // Result port: the buffer read data is turned from an offset digit into
    // the balanced digit code on its way out.
    assign result_valid       = out_vld_reg;
    assign result.trit        = code_from_offset(rd_data_reg);
    assign result.in_fraction = out_frac_reg;
    assign result.truncated   = trunc_reg;
    assign result.last        = out_last_reg;

    // A digit transfer only ever follows a read issued by an output state.
    `ASSERT_IMPLY(a_digit_from_output_pass, clk, rst_n, out_vld_reg, ($past(state_reg) == ST_OUT_I) || ($past(state_reg) == ST_OUT_F))
    // The add-one write-back stays inside the conversion states.
    `ASSERT_IMPLY(a_writeback_in_conversion, clk, rst_n, conv_vld_reg, (state_reg == ST_CONV_F) || (state_reg == ST_CONV_I) || (state_reg == ST_FIN))
    // After the final digit of an item no further digit follows directly.
    `ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_vld_reg && out_last_reg, !out_vld_reg)
    // A command transfer always starts the divider.
    `ASSERT_NEXT(a_start_enters_divide, clk, rst_n, accept, state_reg == ST_DIV)

endmodule

`default_nettype wire

// ===== bench/fraction_to_balanced_ternary_tb.sv =====
// ----------------------------------------------------------------------------
// fraction_to_balanced_ternary_tb
// Self-checking bench for the fraction to balanced ternary converter. It
// sends directed and random fractions and predicts every digit in the bench.
// Each digit transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fraction_to_balanced_ternary_tb;

    import fbt_pkg::*;

    // The integer part of a 31-bit quotient needs at most 20 ternary digits.
    // The slot count below matches the buffer sizing of the block, and one
    // more digit is allowed for a carry out of the top.
    localparam int INT_DIGITS   = (VALUE_BITS_DEF * 7) / 11 + 2;
    localparam int FRAC_DIGITS  = MAX_FRAC_TRITS_DEF;
    localparam int VALUE_MAX    = 2147483647;
    localparam int RANDOM_ITEMS = 97;
    // The last part of the random run is sent back to back, with no gaps.
    localparam int QUIET_TAIL   = 20;
    // The run limit is many times the slowest legal run.
    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int          SETTLE_WAIT = 250;

    // One fraction waiting to go out, with the idle time before it and a flag
    // that holds it back until every digit already predicted has come out.
    typedef struct {
        operand_t    op;
        int unsigned gap;
        bit          drain;
    } fraction_item_t;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    operand_t operand = '0;
    logic     busy;
    logic     result_valid;
    result_t  result;

    fraction_item_t pending_fractions[$];
    result_t        expected_digits[$];
    int unsigned    gap_left    = 0;
    bit             gap_loaded  = 1'b0;
    int unsigned    error_count = 0;
    int unsigned    cycle_count = 0;

    fraction_to_balanced_ternary dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand      (operand),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Works out the digit stream of one fraction and queues it. The quotient
    // is written in plain ternary, the remainder expanded into at most
    // FRAC_DIGITS fraction digits. Adding one to every digit with carry from
    // the least significant fraction digit up gives the offset form, in which
    // 0, 1 and 2 stand for minus one, zero and plus one.
    function automatic void predict_digits(input operand_t op);
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned rem;
        logic [1:0]      int_off [INT_DIGITS + 1];
        logic [1:0]      frac_off [FRAC_DIGITS];
        logic [1:0]      off;
        int              ni;
        int              nf;
        int              top;
        int              total;
        int              i;
        int unsigned     carry;
        int unsigned     sum;
        bit              cut;
        result_t         digit;

        num = 64'(op.numerator);
        den = 64'(op.denominator);
        // A zero divisor is taken as one.
        if (den == 0)
            den = 1;
        quo   = num / den;
        rem   = num % den;
        ni    = 0;
        nf    = 0;
        carry = 0;

        while (quo != 0 && ni < INT_DIGITS)
        begin
            int_off[ni] = 2'(quo % 3);
            quo         = quo / 3;
            ni++;
        end
        // At least one integer digit is always kept.
        if (ni == 0)
        begin
            int_off[0] = 2'd0;
            ni         = 1;
        end

        while (rem != 0 && nf < FRAC_DIGITS)
        begin
            rem          = rem * 3;
            frac_off[nf] = 2'(rem / den);
            rem          = rem % den;
            nf++;
        end
        // An endless fraction is cut off at the digit limit and flagged.
        cut = (rem != 0);

        for (i = nf - 1; i >= 0; i--)
        begin
            sum         = frac_off[i] + 1 + carry;
            carry       = sum / 3;
            frac_off[i] = 2'(sum % 3);
        end
        for (i = 0; i < ni; i++)
        begin
            sum        = int_off[i] + 1 + carry;
            carry      = sum / 3;
            int_off[i] = 2'(sum % 3);
        end
        // A carry out of the top digit becomes a new leading plus one.
        if (carry != 0)
        begin
            int_off[ni] = OFF_POS;
            ni++;
        end

        // Leading zero integer digits and trailing zero fraction digits drop.
        top = ni - 1;
        while (top > 0 && int_off[top] == OFF_ZERO)
            top--;
        while (nf > 0 && frac_off[nf - 1] == OFF_ZERO)
            nf--;

        total = top + 1 + nf;
        for (i = 0; i < total; i++)
        begin
            off = (i <= top) ? int_off[top - i] : frac_off[i - top - 1];
            case (off)
                OFF_NEG:  digit.trit = TRIT_NEG;
                OFF_POS:  digit.trit = TRIT_POS;
                default:  digit.trit = TRIT_ZERO;
            endcase
            digit.in_fraction = (i > top);
            digit.truncated   = cut;
            digit.last        = (i == total - 1);
            expected_digits.push_back(digit);
        end
    endfunction

    function automatic longint unsigned pow3(input int k);
        longint unsigned p;
        int              j;

        p = 1;
        for (j = 0; j < k; j++)
            p = p * 3;
        return p;
    endfunction

    task automatic queue_fraction(input longint unsigned num, input longint unsigned den,
                                  input int unsigned gap, input bit drain);
        fraction_item_t item;

        item.op.numerator   = num[30:0];
        item.op.denominator = den[30:0];
        item.gap            = gap;
        item.drain          = drain;
        pending_fractions.push_back(item);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: digit field %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    // Driver. A fraction is transferred at an edge where start is high and
    // busy is low. The prediction is made at that same edge from the operand
    // that was on the port. While busy is high, start simply stays up. An
    // idle gap is only counted down while the block is free, so that it
    // really delays the next transfer. Start gets at most one assignment per
    // edge, so it is never lowered and raised again in the same step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            operand    <= '0;
            gap_left   <= 0;
            gap_loaded <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                predict_digits(operand);

            if (start && busy)
            begin
                // The transfer has not happened yet, so the fraction is held.
            end
            else if (gap_left > 0)
            begin
                if (!busy)
                    gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_fractions.size() == 0)
                start <= 1'b0;
            else if (pending_fractions[0].drain && (expected_digits.size() != 0 || busy))
                // The sender stalls until every predicted digit has arrived.
                start <= 1'b0;
            else if (pending_fractions[0].gap > 0 && !gap_loaded)
            begin
                gap_left   <= pending_fractions[0].gap;
                gap_loaded <= 1'b1;
                start      <= 1'b0;
            end
            else
            begin
                operand    <= pending_fractions[0].op;
                start      <= 1'b1;
                gap_loaded <= 1'b0;
                void'(pending_fractions.pop_front());
            end
        end
    end

    // Monitor. The receiver cannot stall the block, so every strobed digit is
    // taken at the edge that ends its cycle. It is then checked against the
    // oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_digits.size() == 0)
            begin
                $display("%0t: digit with none expected, expected nothing, actual %0h",
                         $time, result);
                error_count++;
            end
            else
            begin
                check_field("trit", 32'(expected_digits[0].trit), 32'(result.trit));
                check_field("in_fraction", 32'(expected_digits[0].in_fraction),
                            32'(result.in_fraction));
                check_field("truncated", 32'(expected_digits[0].truncated),
                            32'(result.truncated));
                check_field("last", 32'(expected_digits[0].last), 32'(result.last));
                void'(expected_digits.pop_front());
            end
        end
    end

    // A hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("%0t: timeout, %0d fractions pending, %0d digits outstanding",
                     $time, pending_fractions.size(), expected_digits.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        longint unsigned num;
        longint unsigned den;
        int unsigned     gap;
        bit              drain;
        int              n;

        // Directed part. It covers zero, one and the largest value in both
        // fields, a zero divisor, an endless fraction and fractions that end.
        // It also covers a carry out of the top digit, a carry that runs
        // through every digit, and integers with and without leading zeros.
        queue_fraction(0, 1, 0, 0);
        queue_fraction(0, VALUE_MAX, 0, 0);
        queue_fraction(VALUE_MAX, 1, 0, 0);
        queue_fraction(VALUE_MAX, VALUE_MAX, 0, 0);
        queue_fraction(1, VALUE_MAX, 0, 0);
        queue_fraction(VALUE_MAX - 1, VALUE_MAX, 0, 0);
        queue_fraction(5, 0, 0, 0);
        queue_fraction(1, 2, 0, 0);
        queue_fraction(1, 3, 0, 0);
        queue_fraction(2, 3, 0, 0);
        queue_fraction(2, 1, 0, 0);
        queue_fraction(4, 1, 0, 0);
        queue_fraction(13, 1, 0, 0);
        queue_fraction(26, 1, 0, 0);
        queue_fraction(1, 9, 0, 0);
        queue_fraction(8, 9, 0, 0);
        queue_fraction(7, 2, 0, 0);
        queue_fraction(1, 4, 0, 0);
        queue_fraction(40, 27, 0, 0);
        queue_fraction(VALUE_MAX, 2, 0, 0);
        queue_fraction(pow3(19) - 1, 1, 0, 0);
        queue_fraction(VALUE_MAX, pow3(19), 0, 0);
        queue_fraction(1, pow3(19), 0, 0);

        // Random part. There are four kinds of divisor: any value, a power of
        // three so that the fraction ends, a small divisor, and a power of
        // three times a small factor. Numerators of the last two kinds are shifted
        // by a random amount to vary the number of integer digits.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    num = 64'($urandom & VALUE_MAX);
                    den = 64'($urandom & VALUE_MAX);
                end
                1:
                begin
                    num = 64'($urandom & VALUE_MAX);
                    den = pow3($urandom_range(0, 19));
                end
                2:
                begin
                    num = 64'(($urandom & VALUE_MAX) >> $urandom_range(0, 30));
                    den = 64'($urandom_range(1, 40));
                end
                default:
                begin
                    num = 64'(($urandom & VALUE_MAX) >> $urandom_range(0, 24));
                    den = pow3($urandom_range(0, 16)) * $urandom_range(1, 7);
                end
            endcase
            if (den == 0)
                den = 1;
            gap   = (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 1))
                  ? $urandom_range(1, 6) : 0;
            // The first random fraction always waits for a fully drained
            // pipeline; a few later ones do so at random.
            drain = (n == 0) || (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 15) == 0);
            queue_fraction(num, den, gap, drain);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_fractions.size() != 0 || start)
            @(posedge clk);
        while (expected_digits.size() != 0)
            @(posedge clk);
        // Give any stray digit time to show up before the verdict.
        repeat (SETTLE_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fbt_pkg.sv
hw/rtl/fraction_to_balanced_ternary.sv
bench/fraction_to_balanced_ternary_tb.sv
